FILE: src/boxblur_pkg.sv
// Shared constants and types for the 3x3 RGB box blur.
`default_nettype none
package boxblur_pkg;

  localparam int MAX_WIDTH_DEFAULT = 512;
  localparam int MAX_HEIGHT        = 512;
  localparam int MIN_SIZE          = 3;

  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int CFG_W   = 10;
  localparam int ROW_W   = 10;
  localparam int POS_W   = 9;
  localparam int SUM_W   = 12;

  // Register indexes of the configuration port.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

  // floor(s / 9) == (s * 7282) >> 16 for every s below 32768
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = SUM_W + DIV9_MUL_W;

  typedef struct packed {
    logic             emit;
    logic             interior;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

endpackage
`default_nettype wire

FILE: src/box_blur_3x3_rgb_unit.sv
// Top level of the 3x3 RGB box blur: line buffers, window and mean pipeline.
// Output: the result for a centre pixel leaves w+1 window-advancing items after it
//   (w = row width), passing through the input/memory, window, sum and divide registers.
// Throughput: one item per cycle; the line buffers are one-write one-read memories and
//   every stage hands on each cycle unless the output is held.
// Reset: width returns to the lesser of 512 and MAX_WIDTH, height to 512, position and window
//   clear; line buffer contents stay undefined and are only used for rows already written.
`default_nettype none
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = boxblur_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [boxblur_pkg::CFG_W-1:0] wr_data,
  // pixel stream in
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
  input  wire logic        s_tuser,   // flush
  // filtered stream out
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [47:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16],
                                      // out_row [32:24], out_col [41:33], zero [47:42]
  output      logic        m_tlast    // frame_end
);
  import boxblur_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int W_RESET = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
  localparam logic [CW-1:0] W_LAST_RESET = CW'(W_RESET - 1);
  localparam logic [ROW_W-1:0] H_LAST_RESET = ROW_W'(MAX_HEIGHT - 1);

  // ---------------------------------------------------------------------------
  // Configuration: keep only the saturated last column and last row.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;

  // Position of the next input item.
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row_next;
  logic [CW-1:0]    col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= W_LAST_RESET;
      h_last <= H_LAST_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FRAME_WIDTH: begin
          if (wr_data < CFG_W'(MIN_SIZE)) begin
            w_last <= CW'(MIN_SIZE - 1);
          end else if (32'(wr_data) > MAX_WIDTH) begin
            w_last <= CW'(MAX_WIDTH - 1);
          end else begin
            w_last <= CW'(wr_data - CFG_W'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (wr_data < CFG_W'(MIN_SIZE)) begin
            h_last <= ROW_W'(MIN_SIZE - 1);
          end else if (32'(wr_data) > MAX_HEIGHT) begin
            h_last <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_last <= ROW_W'(wr_data - CFG_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode. A flush while pixels are still expected is accepted and
  // dropped; everything else enters the pipeline and moves the window.
  // ---------------------------------------------------------------------------
  logic in_frame;
  logic accept;
  logic enter;
  logic [ROW_W-1:0] cy;
  logic [CW-1:0]    cx;
  meta_t            meta_in;

  assign in_frame = (row <= h_last);
  assign accept   = s_tvalid && s_tready;
  assign enter    = accept && !(in_frame && s_tuser);

  always_comb begin
    // Centre lags the input by w+1 positions in raster order.
    if (col != '0) begin
      cy = row - ROW_W'(1);
      cx = col - CW'(1);
    end else begin
      cy = row - ROW_W'(2);
      cx = w_last;
    end
    meta_in.emit     = !((row == '0) || ((row == ROW_W'(1)) && (col == '0)));
    meta_in.interior = (cy != '0) && (cy < h_last) && (cx != '0) && (cx < w_last);
    meta_in.row      = POS_W'(cy);
    meta_in.col      = POS_W'(cx);
    meta_in.last     = meta_in.emit && (cy == h_last) && (cx == w_last);

    // Wrap to the next row, or restart after the frame's last result.
    if (meta_in.last) begin
      row_next = '0;
      col_next = '0;
    end else if (col == w_last) begin
      row_next = row + ROW_W'(1);
      col_next = '0;
    end else begin
      row_next = row;
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      row <= '0;
      col <= '0;
    end else if (enter) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers. line_above is read-first at the accept edge so the old row
  // comes out while the new pixel goes in; line_two_above takes that old row
  // one stage later, always at a different column than the current read.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] line_above     [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
  logic [PIX_W-1:0] above_rd;
  logic [PIX_W-1:0] two_rd;

  // Stage 1: input register next to the memory read data.
  logic             v1;
  meta_t            meta1;
  logic [PIX_W-1:0] cur1;
  logic             has_mid1;
  logic             has_top1;
  logic [CW-1:0]    addr1;

  logic ld2;
  logic ld3;
  logic ld4;

  always_ff @(posedge clk) begin
    if (enter) begin
      above_rd <= line_above[col];
      two_rd   <= line_two_above[col];
      if (in_frame) begin
        line_above[col] <= s_tdata;
      end
    end
    if (ld2 && has_mid1) begin
      line_two_above[addr1] <= above_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (enter) begin
      v1 <= 1'b1;
    end else if (ld2) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      meta1    <= meta_in;
      cur1     <= in_frame ? s_tdata : '0;
      has_mid1 <= in_frame && (row != '0);
      has_top1 <= in_frame && (row > ROW_W'(1));
      addr1    <= col;
    end
  end

  // Hold the input off while in reset.
  assign s_tready = !rst && (!v1 || ld2);

  // ---------------------------------------------------------------------------
  // Stage 2: shift the window by one column (newest column on the right).
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][PIX_W-1:0] win;   // [column][row], row 2 is the current line
  logic  v2;
  meta_t meta2;

  assign ld2 = v1 && (!v2 || ld3);

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      win <= '0;
    end else if (ld2) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= has_top1 ? two_rd : '0;
      win[2][1] <= has_mid1 ? above_rd : '0;
      win[2][2] <= cur1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= 1'b1;
    end else if (ld3) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      meta2 <= meta1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-channel sum of the nine window pixels.
  // ---------------------------------------------------------------------------
  logic [2:0][SUM_W-1:0] sum_next;
  logic [2:0][SUM_W-1:0] sum3;
  logic  v3;
  meta_t meta3;

  assign ld3 = v2 && (!v3 || ld4);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[2'(ch)] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          sum_next[2'(ch)] = sum_next[2'(ch)]
                           + SUM_W'(win[2'(c)][2'(r)][ch*CHAN_W +: CHAN_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= 1'b1;
    end else if (ld4) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      sum3  <= sum_next;
      meta3 <= meta2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by nine through the reciprocal, zero the border, and hold
  // the result until the sink takes it. Items that make no result drop here.
  // ---------------------------------------------------------------------------
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][CHAN_W-1:0] mean;

  assign ld4 = v3 && (!m_tvalid || m_tready);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[2'(ch)] = PROD_W'(sum3[2'(ch)]) * PROD_W'(DIV9_MUL);
      mean[2'(ch)] = prod[2'(ch)][DIV9_SHIFT +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld4) begin
      m_tvalid <= meta3.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4 && meta3.emit) begin
      m_tdata[7:0]   <= meta3.interior ? mean[0] : '0;
      m_tdata[15:8]  <= meta3.interior ? mean[1] : '0;
      m_tdata[23:16] <= meta3.interior ? mean[2] : '0;
      m_tdata[32:24] <= meta3.row;
      m_tdata[41:33] <= meta3.col;
      m_tdata[47:42] <= '0;
      m_tlast        <= meta3.last;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/box_blur_3x3_rgb_unit_tb.sv
// Self-checking testbench for the 3x3 RGB box blur: random frames against a built-in predictor.
module box_blur_3x3_rgb_unit_tb;
  import boxblur_pkg::*;

  localparam int MAXW         = MAX_WIDTH_DEFAULT;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, enough to back up the block
  localparam int QUIET_LIMIT  = 3000;  // cycles without any transaction before giving up
  localparam int TAIL_CYCLES  = 16;    // pipeline depth plus margin after the last result
  localparam int RANDOM_ITEMS = 620;

  // One filtered pixel as it leaves the block.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              frame_end;
  } blur_px_t;

  // Mirror of the blur datapath plus the queue of filtered pixels still to come out.
  class blur_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] line_up [MAXW];
    logic [PIX_W-1:0] line_up2 [MAXW];
    logic [PIX_W-1:0] win [9];   // col*3 + row; col 2 newest, row 2 lowest
    int unsigned      row_pos;
    int unsigned      col_pos;
    blur_px_t         blurred_q [$];
    int               faults;

    function new();
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      foreach (line_up[i]) begin
        line_up[i]  = '0;
        line_up2[i] = '0;
      end
      faults = 0;
      restart();
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      foreach (win[k]) win[k] = '0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAXW) return MAXW;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_SIZE) return MIN_SIZE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    // Any register write restarts the frame.
    function void write_reg(logic idx, logic [CFG_W-1:0] v);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      restart();
    endfunction

    function int pending();
      return blurred_q.size();
    endfunction

    // Advance the window by one accepted item and queue the pixel it completes, if any.
    function void note_input(logic [PIX_W-1:0] data, logic flush);
      int unsigned w, h, r, c, y, x, sum;
      logic [PIX_W-1:0] top, mid, cur;
      logic [CHAN_W-1:0] mean [3];
      blur_px_t res;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      top = '0;
      mid = '0;
      cur = '0;
      if (c >= w) c = w - 1;
      if (r < h) begin
        // flush inside the frame is dropped without a trace
        if (flush) return;
        cur = data;
        if (r >= 2) top = line_up2[c];
        if (r >= 1) begin
          mid = line_up[c];
          line_up2[c] = mid;
        end
        line_up[c] = cur;
      end
      for (int k = 0; k < 6; k++) win[k] = win[k+3];
      win[6] = top;
      win[7] = mid;
      win[8] = cur;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
      if (r == 0 || (r == 1 && c == 0)) return;
      if (c >= 1) begin
        y = r - 1;
        x = c - 1;
      end else begin
        y = r - 2;
        x = w - 1;
      end
      for (int ch = 0; ch < 3; ch++) begin
        mean[ch] = '0;
        if (y >= 1 && y + 1 < h && x >= 1 && x + 1 < w) begin
          sum = 0;
          for (int k = 0; k < 9; k++) sum += 32'(win[k][8*ch +: 8]);
          mean[ch] = CHAN_W'(sum / 9);
        end
      end
      res.red       = mean[0];
      res.green     = mean[1];
      res.blue      = mean[2];
      res.row       = POS_W'(y);
      res.col       = POS_W'(x);
      res.frame_end = (y == h - 1 && x == w - 1);
      if (res.frame_end) begin
        row_pos = 0;
        col_pos = 0;
      end
      blurred_q.push_back(res);
    endfunction

    function void check_output(logic [47:0] data, logic frame_end);
      blur_px_t got, want;
      got = {data[7:0], data[15:8], data[23:16], data[32:24], data[41:33], frame_end};
      if (blurred_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected output pixel at row %0d col %0d", got.row, got.col);
        return;
      end
      want = blurred_q.pop_front();
      if (got != want) begin
        faults++;
        if (faults <= 10) begin
          $display("pixel mismatch: expected rgb %0d/%0d/%0d at %0d,%0d end %0b,",
                   want.red, want.green, want.blue, want.row, want.col, want.frame_end);
          $display("  got rgb %0d/%0d/%0d at %0d,%0d end %0b",
                   got.red, got.green, got.blue, got.row, got.col, got.frame_end);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en = 1'b0;
  logic              wr_index = 1'b0;
  logic [CFG_W-1:0]  wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;   // in_red [7:0], in_green [15:8], in_blue [23:16]
  logic              s_tuser = 1'b0; // flush
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;        // out_red, out_green, out_blue, out_row, out_col, zero
  logic              m_tlast;        // frame_end

  blur_scoreboard sb = new();

  bit steady   = 1'b0;  // last part of the run: no idling on either side
  bit tx_calm  = 1'b0;  // stretch without sender gaps
  bit rx_calm  = 1'b0;  // stretch without receiver stalls
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  int fed;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_blur_3x3_rgb_unit #(
    .MAX_WIDTH(MAXW)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Favor the channel extremes so the nine-pixel sums reach their limits.
  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    return {pick_chan(), pick_chan(), pick_chan()};
  endfunction

  // Mostly small sizes, now and then a value below range that saturates to the minimum.
  function automatic logic [CFG_W-1:0] pick_size(int hi);
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, MIN_SIZE - 1));
    return CFG_W'($urandom_range(MIN_SIZE, hi));
  endfunction

  // Offer one item, with an occasional gap first, and hold it until the transaction completes.
  task automatic push_item(logic [PIX_W-1:0] data, logic flush);
    if (!steady && !tx_calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= flush;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(data, flush);
  endtask

  // Pulse one register write, then hold wr_en low before returning so back-to-back writes never clash.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every queued pixel, then let the pipeline empty out.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Send the pixels of one frame at the current size; a short stop_at leaves the frame
  // unfinished, otherwise drain the last row with width+1 trailing items.
  task automatic feed_frame(int stop_at, bit noisy, int hold_at);
    int w, h, total;
    w = sb.eff_width();
    h = sb.eff_height();
    total = w * h;
    for (int i = 0; i < total && i < stop_at; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      // stray flush inside the frame: the block must ignore it
      if (noisy && $urandom_range(0, 19) == 0) push_item(random_pixel(), 1'b1);
      push_item(random_pixel(), 1'b0);
      fed++;
    end
    if (stop_at >= total) begin
      for (int i = 0; i <= w; i++) begin
        // a pixel after the frame is complete acts as a flush and its data is dropped
        if (noisy && $urandom_range(0, 5) == 0) push_item(random_pixel(), 1'b0);
        else push_item(random_pixel(), 1'b1);
        fed++;
      end
    end
  endtask

  // Receiver: short random stalls, calm stretches, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!steady && !rx_calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare every output transaction with the oldest predicted pixel.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
  end

  // Watchdog: abort when no transaction happens on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned total, stop;
    bit [1:0] mode;
    bit aligned;
    fed = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset size is 512 x 512: run into the second row and stop mid-frame.
    // Hold the receiver off once results flow so the block fills and stalls its input.
    feed_frame(MAXW + 12, 1'b0, MAXW + 1);
    wait_results();

    // Smallest frame: extremes of the channels, a stray flush in the frame,
    // a pixel during the drain, then a second frame without a register write.
    write_reg(REG_FRAME_WIDTH, CFG_W'(MIN_SIZE));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(MIN_SIZE));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_item(24'h5a5a5a, 1'b1);
      push_item((i % 2 == 1) ? 24'hffffff : 24'h000000, 1'b0);
    end
    push_item(24'h000000, 1'b1);
    push_item(24'hffffff, 1'b1);
    push_item(24'habcdef, 1'b0);
    push_item(24'h123456, 1'b1);
    for (int i = 0; i < 9; i++) push_item(24'hffffff, 1'b0);
    for (int i = 0; i < 4; i++) push_item(24'h00ff00, 1'b1);
    wait_results();

    // Full width, all-ones height: a few pixels only, no output expected.
    write_reg(REG_FRAME_HEIGHT, '1);
    write_reg(REG_FRAME_WIDTH, CFG_W'(MAXW));
    feed_frame(30, 1'b1, -1);
    wait_results();

    // Random frames: small sizes, some cut short, some chained without a write.
    write_reg(REG_FRAME_WIDTH, pick_size(14));
    write_reg(REG_FRAME_HEIGHT, pick_size(9));
    aligned = 1'b1;
    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      mode = aligned ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 3));
      if (mode != 2'd0 || $urandom_range(0, 4) == 0) wait_results();
      if (mode[0]) write_reg(REG_FRAME_WIDTH, pick_size(14));
      if (mode[1]) write_reg(REG_FRAME_HEIGHT, pick_size(9));
      total = sb.eff_width() * sb.eff_height();
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
      aligned = (stop == total);
      steady  = (fed > RANDOM_ITEMS - 150);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      feed_frame(stop, 1'b1, (!steady && $urandom_range(0, 11) == 0) ? 0 : -1);
    end

    wait_results();
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: box_blur_3x3_rgb_unit.f
src/boxblur_pkg.sv
src/box_blur_3x3_rgb_unit.sv
tb/sv/box_blur_3x3_rgb_unit_tb.sv
